>>> rtl/core/qpd_pkg.sv
`default_nettype none

package qpd_pkg;

   // Default sizing of the block.
   localparam int SAMPLE_BITS_DEF = 12;
   localparam int MAX_GROUPS_DEF  = 64;

   // Window register.
   localparam int          WINDOW_BITS  = 7;
   localparam logic [6:0]  WINDOW_RESET = 7'd9;

   // Result fields.
   localparam int POWER_BITS  = 29;
   localparam int SUM_BITS    = 20;
   localparam int POWER_SHIFT = 8;

   // Stream data widths, padded to whole bytes.
   localparam int REQ_TDATA_BITS = 16;
   localparam int RSP_TDATA_BITS = 72;

   // Carrier phase within one four-sample group.
   typedef enum logic [1:0] {
      PHASE_0 = 2'd0,
      PHASE_1 = 2'd1,
      PHASE_2 = 2'd2,
      PHASE_3 = 2'd3
   } qpd_phase_type;

endpackage

`default_nettype wire

>>> rtl/core/qpd_accum.sv
`default_nettype none

module qpd_accum
   import qpd_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int MAX_GROUPS  = MAX_GROUPS_DEF,
   localparam int ACC_BITS   = SAMPLE_BITS + 2 + $clog2(MAX_GROUPS)
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_we,
   input  wire  [WINDOW_BITS-1:0]           csr_wdata,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [REQ_TDATA_BITS-1:0]        req_tdata,
   output logic                             sum_valid,
   input  wire                              sum_ready,
   output logic signed [ACC_BITS-1:0]       sum_i,
   output logic signed [ACC_BITS-1:0]       sum_q
);

   localparam int GCW = $clog2(MAX_GROUPS + 1);
   localparam int CW  = (GCW > WINDOW_BITS) ? GCW : WINDOW_BITS;

   logic [WINDOW_BITS-1:0]       window_ff;
   qpd_phase_type                phase_ff, phase_in;
   logic [GCW-1:0]               count_ff, count_in;
   logic signed [ACC_BITS-1:0]   acc_i_ff, acc_i_in;
   logic signed [ACC_BITS-1:0]   acc_q_ff, acc_q_in;
   logic                         sum_valid_ff, sum_valid_in;
   logic signed [ACC_BITS-1:0]   sum_i_ff, sum_i_in;
   logic signed [ACC_BITS-1:0]   sum_q_ff, sum_q_in;

   logic                         accept;
   logic signed [ACC_BITS-1:0]   smp;
   logic signed [ACC_BITS-1:0]   next_i, next_q;
   logic [CW-1:0]                win_eff, count_next;
   logic                         group_end, window_end;

   // A sample is taken unless it closes a window while the finished-sum
   // register is full and not draining.
   assign req_tready = !sum_valid_ff || sum_ready || !window_end;
   assign accept     = req_tvalid && req_tready;

   assign smp = ACC_BITS'($signed({1'b0, req_tdata[SAMPLE_BITS-1:0]}));

   // Mix with the quarter-rate carrier: I follows + - - +, Q follows + + - -.
   always_comb begin
      unique case (phase_ff)
         PHASE_0: begin
            next_i = acc_i_ff + smp;
            next_q = acc_q_ff + smp;
         end
         PHASE_1: begin
            next_i = acc_i_ff - smp;
            next_q = acc_q_ff + smp;
         end
         PHASE_2: begin
            next_i = acc_i_ff - smp;
            next_q = acc_q_ff - smp;
         end
         PHASE_3: begin
            next_i = acc_i_ff + smp;
            next_q = acc_q_ff - smp;
         end
         default: begin
            next_i = acc_i_ff;
            next_q = acc_q_ff;
         end
      endcase
   end

   // Effective window: zero acts as one, large values clip to the maximum.
   always_comb begin
      if (window_ff == '0) begin
         win_eff = CW'(1);
      end else if (CW'(window_ff) > CW'(MAX_GROUPS)) begin
         win_eff = CW'(MAX_GROUPS);
      end else begin
         win_eff = CW'(window_ff);
      end
   end

   assign count_next = CW'(count_ff) + CW'(1);
   assign group_end  = (phase_ff == PHASE_3);
   assign window_end = group_end && (count_next >= win_eff);

   // Next state of the accumulators and the finished-sum register.
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      acc_i_in     = acc_i_ff;
      acc_q_in     = acc_q_ff;
      sum_valid_in = sum_valid_ff && !sum_ready;
      sum_i_in     = sum_i_ff;
      sum_q_in     = sum_q_ff;
      if (accept) begin
         phase_in = qpd_phase_type'(phase_ff + 2'd1);
         if (window_end) begin
            count_in     = '0;
            acc_i_in     = '0;
            acc_q_in     = '0;
            sum_valid_in = 1'b1;
            sum_i_in     = next_i;
            sum_q_in     = next_q;
         end else begin
            acc_i_in = next_i;
            acc_q_in = next_q;
            if (group_end) begin
               count_in = GCW'(count_next);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         phase_ff     <= PHASE_0;
         count_ff     <= '0;
         acc_i_ff     <= '0;
         acc_q_ff     <= '0;
         sum_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            window_ff <= csr_wdata;
         end
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         acc_i_ff     <= acc_i_in;
         acc_q_ff     <= acc_q_in;
         sum_valid_ff <= sum_valid_in;
      end
   end

   // Sum payload needs no reset.
   always_ff @(posedge clock) begin
      sum_i_ff <= sum_i_in;
      sum_q_ff <= sum_q_in;
   end

   assign sum_valid = sum_valid_ff;
   assign sum_i     = sum_i_ff;
   assign sum_q     = sum_q_ff;

endmodule

`default_nettype wire

>>> rtl/core/qpd_power.sv
`default_nettype none

module qpd_power
   import qpd_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int MAX_GROUPS  = MAX_GROUPS_DEF,
   localparam int ACC_BITS   = SAMPLE_BITS + 2 + $clog2(MAX_GROUPS)
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              sum_valid,
   output logic                             sum_ready,
   input  wire  signed [ACC_BITS-1:0]       sum_i,
   input  wire  signed [ACC_BITS-1:0]       sum_q,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [RSP_TDATA_BITS-1:0]        rsp_tdata
);

   localparam int HALF_BITS = ACC_BITS - 1;
   localparam int SQ_BITS   = 2 * HALF_BITS;
   localparam int TOT_BITS  = SQ_BITS + 1;

   logic signed [HALF_BITS-1:0]  half_i, half_q;
   logic signed [SQ_BITS-1:0]    prod_i, prod_q;
   logic [TOT_BITS-1:0]          total;

   logic                         sq_valid_ff;
   logic [SQ_BITS-1:0]           sq_i_ff, sq_q_ff;
   logic signed [SUM_BITS-1:0]   sq_si_ff, sq_sq_ff;
   logic                         out_valid_ff;
   logic [POWER_BITS-1:0]        out_power_ff;
   logic signed [SUM_BITS-1:0]   out_i_ff, out_q_ff;

   logic                         out_adv, sq_adv;

   // Stage moves on when the stage after it is empty or draining.
   assign out_adv   = !out_valid_ff || rsp_tready;
   assign sq_adv    = !sq_valid_ff || out_adv;
   assign sum_ready = sq_adv;

   // Halve with an arithmetic shift, then square each sum.
   assign half_i = HALF_BITS'(sum_i >>> 1);
   assign half_q = HALF_BITS'(sum_q >>> 1);
   assign prod_i = half_i * half_i;
   assign prod_q = half_q * half_q;

   // Add the registered squares and scale down.
   assign total = TOT_BITS'(sq_i_ff) + TOT_BITS'(sq_q_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (sq_adv) begin
            sq_valid_ff <= sum_valid;
         end
         if (out_adv) begin
            out_valid_ff <= sq_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sq_adv) begin
         sq_i_ff  <= $unsigned(prod_i);
         sq_q_ff  <= $unsigned(prod_q);
         sq_si_ff <= SUM_BITS'(sum_i);
         sq_sq_ff <= SUM_BITS'(sum_q);
      end
      if (out_adv) begin
         out_power_ff <= POWER_BITS'(total >> POWER_SHIFT);
         out_i_ff     <= sq_si_ff;
         out_q_ff     <= sq_sq_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_BITS'({out_q_ff, out_i_ff, out_power_ff});

endmodule

`default_nettype wire

>>> rtl/core/quadrature_iq_power_detector_core.sv
// Quarter-rate quadrature downconverter with power detector.
//
// Input channel req_*: one unsigned ADC sample per item in req_tdata.
// Result channel rsp_*: one item per window, carrying the power
// ((I>>1)^2 + (Q>>1)^2) >> 8 and the raw I and Q sums of the window.
// csr_we/csr_wdata write the window length in four-sample groups (0 acts
// as 1, values above MAX_GROUPS act as MAX_GROUPS); write it only while idle.
//
// Throughput is one sample per clock while req_tready is high: samples are
// mixed and accumulated as they are accepted. The edge that accepts a
// window's last sample loads the sum register; the square register and then
// the output register load after it, with the multiplier before the square
// register and the adder and shift before the output register.
// When the receiver stalls, the result holds in the output register and
// the square and sum registers fill behind it; req_tready drops only when
// a window ends while all three are occupied.
// Synchronous reset clears the sums, phase and group count, empties the
// pipeline and sets the window to nine groups.

`default_nettype none

module quadrature_iq_power_detector_core
   import qpd_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int MAX_GROUPS  = MAX_GROUPS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_we,
   input  wire  [WINDOW_BITS-1:0]       csr_wdata,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [REQ_TDATA_BITS-1:0]    req_tdata,   // [11:0] sample
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [RSP_TDATA_BITS-1:0]    rsp_tdata    // [28:0] power, [48:29] in_phase,
                                                     // [68:49] quadrature
);

   localparam int ACC_BITS = SAMPLE_BITS + 2 + $clog2(MAX_GROUPS);

   logic                        sum_valid, sum_ready;
   logic signed [ACC_BITS-1:0]  sum_i, sum_q;

   // Mixer and window accumulators.
   qpd_accum #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_GROUPS  (MAX_GROUPS)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .sum_valid  (sum_valid),
      .sum_ready  (sum_ready),
      .sum_i      (sum_i),
      .sum_q      (sum_q)
   );

   // Squaring and output register.
   qpd_power #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_GROUPS  (MAX_GROUPS)
   ) u_power (
      .clock      (clock),
      .reset      (reset),
      .sum_valid  (sum_valid),
      .sum_ready  (sum_ready),
      .sum_i      (sum_i),
      .sum_q      (sum_q),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

>>> rtl/core/qpd_checker.sv
`default_nettype none

module qpd_checker
   import qpd_pkg::*;
(
   input wire                          clock,
   input wire                          reset,
   input wire                          req_tready,
   input wire                          rsp_tvalid,
   input wire                          rsp_tready,
   input wire  [RSP_TDATA_BITS-1:0]    rsp_tdata
);

   logic signed [SUM_BITS-1:0]    chk_i, chk_q;
   logic signed [SUM_BITS-2:0]    chk_hi, chk_hq;
   logic signed [2*SUM_BITS-3:0]  chk_sqi, chk_sqq;
   logic [2*SUM_BITS-1:0]         chk_total;
   logic [POWER_BITS-1:0]         chk_power;

   // Recompute the power from the sums shown on the result channel.
   assign chk_i     = rsp_tdata[POWER_BITS +: SUM_BITS];
   assign chk_q     = rsp_tdata[POWER_BITS + SUM_BITS +: SUM_BITS];
   assign chk_hi    = (SUM_BITS - 1)'(chk_i >>> 1);
   assign chk_hq    = (SUM_BITS - 1)'(chk_q >>> 1);
   assign chk_sqi   = chk_hi * chk_hi;
   assign chk_sqq   = chk_hq * chk_hq;
   assign chk_total = (2 * SUM_BITS)'($unsigned(chk_sqi))
                    + (2 * SUM_BITS)'($unsigned(chk_sqq));
   assign chk_power = POWER_BITS'(chk_total >> POWER_SHIFT);

   // The output register is empty in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   // A stalled result keeps its data.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // With the output register empty the whole pipeline can take a sample.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with an empty output register");

   // Power agrees with the sums it travels with, and the padding is zero.
   a_power_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[POWER_BITS-1:0] == chk_power
                     && rsp_tdata[RSP_TDATA_BITS-1:POWER_BITS + 2*SUM_BITS] == '0)
      else $error("power does not match the sums");

endmodule

bind quadrature_iq_power_detector_core qpd_checker u_qpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

>>> tb/quadrature_iq_power_detector_core_test.sv
`timescale 1ns / 100ps

module quadrature_iq_power_detector_core_test;
   import qpd_pkg::*;

   // One power result as it leaves the block.
   typedef struct packed {
      logic [POWER_BITS-1:0] power;
      logic [SUM_BITS-1:0]   in_phase;
      logic [SUM_BITS-1:0]   quadrature;
   } iq_window_type;

   // One directed window of four samples; the result is typed in when known is set.
   typedef struct packed {
      logic [11:0]    s0;
      logic [11:0]    s1;
      logic [11:0]    s2;
      logic [11:0]    s3;
      logic           known;
      iq_window_type  result;
   } window_row_type;

   // Ways of filling a phase with samples.
   typedef enum int {
      FILL_UNIFORM  = 0,
      FILL_EXTREMES = 1,
      FILL_TONE     = 2,
      FILL_FULL     = 3
   } fill_kind_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      csr_we     = 1'b0;
   logic [WINDOW_BITS-1:0]    csr_wdata  = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;

   quadrature_iq_power_detector_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Mirror of the block's state and window register.
   qpd_phase_type          mix_phase    = PHASE_0;
   longint                 sum_in_phase = 0;
   longint                 sum_quad     = 0;
   int unsigned            groups_done  = 0;
   logic [WINDOW_BITS-1:0] window_reg   = WINDOW_RESET;

   iq_window_type  pending_windows[$];
   int unsigned error_count    = 0;
   int unsigned samples_sent   = 0;
   int unsigned windows_seen   = 0;
   int unsigned settings_used  = 0;
   int unsigned burst_left     = 0;

   // Directed windows, run with the window register written as zero (acts as one).
   localparam int DIRECTED_ROWS = 6;
   window_row_type directed_windows [0:DIRECTED_ROWS-1] = '{
      '{12'd0,    12'd0,    12'd0,    12'd0,    1'b1, '{29'd0,     20'sd0,     20'sd0}},
      '{12'd4095, 12'd0,    12'd0,    12'd4095, 1'b1, '{29'd65504, 20'sd8190,  20'sd0}},
      '{12'd0,    12'd4095, 12'd4095, 12'd0,    1'b1, '{29'd65504, -20'sd8190, 20'sd0}},
      '{12'd4095, 12'd4095, 12'd0,    12'd0,    1'b1, '{29'd65504, 20'sd0,     20'sd8190}},
      '{12'd0,    12'd0,    12'd4095, 12'd4095, 1'b1, '{29'd65504, 20'sd0,     -20'sd8190}},
      '{12'h800,  12'h7FF,  12'h555,  12'hAAA,  1'b0, '{29'd0,     20'sd0,     20'sd0}}
   };

   // Mix one sample into the sums; fires when the window closes on a group boundary.
   task automatic mix_sample(input logic [11:0] sample, output bit fire,
                             output iq_window_type result);
      int unsigned span;
      longint      half_i;
      longint      half_q;
      longint      pow_wide;
      fire = 1'b0;
      result = '0;
      if (mix_phase == PHASE_0 || mix_phase == PHASE_3) sum_in_phase += sample;
      else sum_in_phase -= sample;
      if (mix_phase == PHASE_0 || mix_phase == PHASE_1) sum_quad += sample;
      else sum_quad -= sample;
      mix_phase = qpd_phase_type'(mix_phase + 2'd1);
      if (mix_phase == PHASE_0) begin
         groups_done++;
         span = (window_reg == 0) ? 1 : ((window_reg > MAX_GROUPS_DEF) ? MAX_GROUPS_DEF
                                                                      : window_reg);
         if (groups_done >= span) begin
            half_i = sum_in_phase >>> 1;
            half_q = sum_quad >>> 1;
            pow_wide = (half_i * half_i + half_q * half_q) >>> POWER_SHIFT;
            result.power      = pow_wide[POWER_BITS-1:0];
            result.in_phase   = sum_in_phase[SUM_BITS-1:0];
            result.quadrature = sum_quad[SUM_BITS-1:0];
            fire = 1'b1;
            sum_in_phase = 0;
            sum_quad = 0;
            groups_done = 0;
         end
      end
   endtask

   // Offer one sample, bursting with random gaps; entered and left just after a falling edge.
   task automatic send_sample(input logic [11:0] sample, input bit typed,
                              input iq_window_type typed_result);
      int unsigned   gap;
      bit            fire;
      iq_window_type result;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                                  : $urandom_range(1, 24);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_BITS-12){1'b0}}, sample};
      do @(posedge clock); while (!req_tready);
      mix_sample(sample, fire, result);
      if (typed) pending_windows.push_back(typed_result);
      else if (fire) pending_windows.push_back(result);
      samples_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   // Let the block drain, then write the window register.
   task automatic set_window(input logic [WINDOW_BITS-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_windows.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      window_reg = value;
      settings_used++;
   endtask

   // Receiver alternates ready and stalled stretches of random length.
   bit          rsp_on  = 1'b0;
   int unsigned rsp_run = 0;
   always @(negedge clock) begin
      if (rsp_run == 0) begin
         rsp_on = !rsp_on;
         if (rsp_on) rsp_run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200)
                                                           : $urandom_range(1, 12);
         else rsp_run = $urandom_range(1, 10);
      end
      rsp_run--;
      rsp_tready <= rsp_on;
   end

   // Compare every accepted result with the oldest expected window.
   always @(posedge clock) begin
      iq_window_type got;
      iq_window_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.power      = rsp_tdata[28:0];
         got.in_phase   = rsp_tdata[48:29];
         got.quadrature = rsp_tdata[68:49];
         if (pending_windows.size() == 0) begin
            $error("unexpected result: power %0d, in_phase %0d, quadrature %0d",
                   got.power, $signed(got.in_phase), $signed(got.quadrature));
            error_count++;
         end else begin
            want = pending_windows.pop_front();
            windows_seen++;
            if (got.power !== want.power) begin
               $error("power: expected %0d, got %0d", want.power, got.power);
               error_count++;
            end
            if (got.in_phase !== want.in_phase) begin
               $error("in_phase: expected %0d, got %0d",
                      $signed(want.in_phase), $signed(got.in_phase));
               error_count++;
            end
            if (got.quadrature !== want.quadrature) begin
               $error("quadrature: expected %0d, got %0d",
                      $signed(want.quadrature), $signed(got.quadrature));
               error_count++;
            end
         end
      end
   end

   // Main sequence: directed windows, then random phases over many window settings.
   initial begin
      int unsigned    item_count;
      int unsigned    pick;
      fill_kind_type  fill;
      logic [11:0]    tone [0:3];
      logic [11:0]    sample;
      logic [WINDOW_BITS-1:0] next_window;
      int unsigned    rot;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: a window of zero groups acts as one group.
      set_window(7'd0);
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         send_sample(directed_windows[r].s0, 1'b0, '0);
         send_sample(directed_windows[r].s1, 1'b0, '0);
         send_sample(directed_windows[r].s2, 1'b0, '0);
         send_sample(directed_windows[r].s3, directed_windows[r].known,
                     directed_windows[r].result);
      end

      // Random phases; the first few pin the extremes, the rest are mostly short windows.
      for (int p = 0; samples_sent < 930; p++) begin
         case (p)
            0: begin next_window = 7'd127; item_count = 260; fill = FILL_FULL; end
            1: begin next_window = 7'd64;  item_count = 150; fill = FILL_TONE; end
            2: begin next_window = 7'd2;   item_count = 60;  fill = FILL_TONE; end
            3: begin next_window = 7'd1;   item_count = 40;  fill = FILL_UNIFORM; end
            default: begin
               next_window = ($urandom_range(0, 3) == 0)
                           ? WINDOW_BITS'($urandom_range(0, 127))
                           : WINDOW_BITS'($urandom_range(1, 8));
               item_count = $urandom_range(24, 90);
               pick = $urandom_range(0, 9);
               fill = (pick < 6) ? FILL_TONE : (pick < 8) ? FILL_UNIFORM
                    : (pick < 9) ? FILL_EXTREMES : FILL_FULL;
            end
         endcase
         set_window(next_window);

         // A tone repeats one value per carrier phase, so the sums grow coherently.
         if (fill == FILL_FULL) begin
            rot = $urandom_range(0, 3);
            for (int k = 0; k < 4; k++)
               tone[(k + rot) % 4] = (k == 0 || k == 3) ? 12'd4095 : 12'd0;
         end else begin
            for (int k = 0; k < 4; k++) tone[k] = 12'($urandom_range(0, 4095));
         end

         for (int n = 0; n < item_count; n++) begin
            case (fill)
               FILL_UNIFORM:  sample = 12'($urandom_range(0, 4095));
               FILL_EXTREMES: sample = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
               FILL_FULL:     sample = tone[mix_phase];
               default:       sample = tone[mix_phase] ^ 12'($urandom_range(0, 7));
            endcase
            send_sample(sample, 1'b0, '0);
         end
      end

      // Drain and let the pipeline settle.
      req_tvalid <= 1'b0;
      while (pending_windows.size() != 0) @(negedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d samples under %0d window settings; %0d power results checked.",
               samples_sent, settings_used, windows_seen);
      if (error_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #400000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
